// ----- sv/bgbt_pkg.sv -----
// ----------------------------------------------------------------------------
// Battery gauge / backlight timer package
// Shared types, operation codes, register indexes and reset constants.
// ----------------------------------------------------------------------------
package bgbt_pkg;

	// Operation codes carried in the request
	localparam logic [1:0] OP_TICK    = 2'd0;
	localparam logic [1:0] OP_MEASURE = 2'd1;
	localparam logic [1:0] OP_WAKE    = 2'd2;
	localparam logic [1:0] OP_RECEIVE = 2'd3;

	// Configuration register indexes
	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_BL_RELOAD    = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BL_OFF_LEVEL = 8'd1;

	// Reset values and fixed constants
	localparam logic [7:0]  BL_RELOAD_RESET = 8'd23;
	localparam logic [7:0]  BL_OFF_RESET    = 8'd18;
	localparam logic [3:0]  ICON_FULL       = 4'hB;
	localparam logic [3:0]  ICON_EMPTY      = 4'hF;
	localparam logic [3:0]  ICON_WRAP       = 4'hA;
	localparam logic [12:0] MV_SCALE        = 13'd6590;
	localparam logic [11:0] MV_DIV          = 12'd4095;
	localparam logic [5:0]  ASCII_ZERO      = 6'h30;
	localparam logic [15:0] ADDR_STEP       = 16'd256;
	localparam logic [7:0]  TIMEOUT_LOAD    = 8'd2;

	typedef struct packed {
		logic [1:0]  operation;
		logic        charging_mode;
		logic        idle_mode;
		logic        charge_done_pin;
		logic [11:0] sample0;
		logic [11:0] sample1;
		logic [11:0] sample2;
		logic [11:0] sample3;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  battery_code;
		logic        battery_low;
		logic        backlight_on;
		logic        power_release;
		logic        timeout_flag;
		logic [12:0] millivolts;
		logic [5:0]  digit_thousands;
		logic [5:0]  digit_hundreds;
		logic [5:0]  digit_tens;
		logic [5:0]  digit_units;
		logic [15:0] block_address;
	} res_item_t;

	// Control part of a request that travels down the pipeline
	typedef struct packed {
		logic [1:0] operation;
		logic       charging_mode;
		logic       idle_mode;
		logic       charge_done_pin;
	} ctl_t;

	// Request as it enters the state update stage
	typedef struct packed {
		ctl_t        ctl;
		logic [12:0] mv;
		logic [3:0]  dig_th;
		logic [3:0]  dig_hu;
		logic [6:0]  rem;
		logic        cls_hit;
		logic [3:0]  cls_code;
		logic        cls_low;
	} meas_t;

	typedef struct packed {
		logic                 valid;
		logic [CFG_IDX_W-1:0] index;
		logic [7:0]           data;
	} cfg_wr_t;

	// Largest k in 0..9 with k*step <= v. The compares are independent.
	function automatic logic [3:0] lead_digit(input logic [13:0] v, input logic [13:0] step);
		logic [3:0] d;
		d = '0;
		for (int k = 1; k <= 9; k++) begin
			if (v >= 14'(k) * step) begin
				d = 4'(k);
			end
		end
		return d;
	endfunction

endpackage

// ----- sv/bgbt_state.sv -----
// ----------------------------------------------------------------------------
// Battery gauge state update
// Holds the event state and configuration, applies one request per update.
// ----------------------------------------------------------------------------
module bgbt_state (
	input  logic                clk,
	input  logic                arst_n,
	input  bgbt_pkg::cfg_wr_t   cfg,
	input  logic                upd,
	input  bgbt_pkg::meas_t     item,
	output bgbt_pkg::res_item_t res
);
	import bgbt_pkg::*;

	logic [7:0]  reload_q, off_q;
	logic [3:0]  icon_q, icon_n;
	logic [7:0]  bl_cnt_q, bl_cnt_n;
	logic        bl_en_q, bl_en_n;
	logic [7:0]  to_cnt_q, to_cnt_n;
	logic [15:0] addr_q, addr_n;
	logic [12:0] mv_q, mv_n;
	logic [3:0]  dth_q, dth_n, dhu_q, dhu_n, dte_q, dte_n, dun_q, dun_n;
	logic [3:0]  icon_dec, tens;
	logic        low, release_p, tflag;

	assign tens = lead_digit({7'b0, item.rem}, 14'd10);

	always_comb begin
		icon_n    = icon_q;
		bl_cnt_n  = bl_cnt_q;
		bl_en_n   = bl_en_q;
		to_cnt_n  = to_cnt_q;
		addr_n    = addr_q;
		mv_n      = mv_q;
		dth_n     = dth_q;
		dhu_n     = dhu_q;
		dte_n     = dte_q;
		dun_n     = dun_q;
		low       = 1'b0;
		release_p = 1'b0;
		tflag     = 1'b0;
		icon_dec  = icon_q - 4'd1;
		unique case (item.ctl.operation)
			OP_TICK: begin
				// Charge animation steps the icon down and wraps past full.
				if (item.ctl.charging_mode &&
				    !(icon_q == ICON_FULL && item.ctl.charge_done_pin)) begin
					icon_n = (icon_dec == ICON_WRAP) ? ICON_EMPTY : icon_dec;
				end
				if (bl_cnt_q != 8'd0) begin
					bl_cnt_n = bl_cnt_q - 8'd1;
				end else if (item.ctl.idle_mode) begin
					release_p = 1'b1;
				end
				if (bl_cnt_n < off_q) begin
					bl_en_n = 1'b0;
				end
				to_cnt_n = to_cnt_q - 8'd1;
				tflag    = (to_cnt_n == 8'd0);
			end
			OP_MEASURE: begin
				if (item.cls_hit) begin
					icon_n = item.cls_code;
				end
				low      = item.cls_low;
				mv_n     = item.mv;
				dth_n    = item.dig_th;
				dhu_n    = item.dig_hu;
				dte_n    = tens;
				dun_n    = 4'(item.rem - 7'(tens) * 7'd10);
				bl_cnt_n = reload_q;
				bl_en_n  = 1'b1;
			end
			OP_WAKE: begin
				bl_cnt_n = reload_q;
				bl_en_n  = 1'b1;
			end
			OP_RECEIVE: begin
				addr_n   = addr_q + ADDR_STEP;
				to_cnt_n = TIMEOUT_LOAD;
			end
		endcase

		res.battery_code    = icon_n;
		res.battery_low     = low;
		res.backlight_on    = bl_en_n;
		res.power_release   = release_p;
		res.timeout_flag    = tflag;
		res.millivolts      = mv_n;
		res.digit_thousands = ASCII_ZERO | {2'b00, dth_n};
		res.digit_hundreds  = ASCII_ZERO | {2'b00, dhu_n};
		res.digit_tens      = ASCII_ZERO | {2'b00, dte_n};
		res.digit_units     = ASCII_ZERO | {2'b00, dun_n};
		res.block_address   = addr_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q <= BL_RELOAD_RESET;
			off_q    <= BL_OFF_RESET;
			icon_q   <= ICON_EMPTY;
			bl_cnt_q <= BL_RELOAD_RESET;
			bl_en_q  <= 1'b1;
			to_cnt_q <= '0;
			addr_q   <= '0;
			mv_q     <= '0;
			dth_q    <= '0;
			dhu_q    <= '0;
			dte_q    <= '0;
			dun_q    <= '0;
		end else begin
			if (cfg.valid) begin
				if (cfg.index == REG_BL_RELOAD) begin
					reload_q <= cfg.data;
				end else if (cfg.index == REG_BL_OFF_LEVEL) begin
					off_q <= cfg.data;
				end
			end
			if (upd) begin
				icon_q   <= icon_n;
				bl_cnt_q <= bl_cnt_n;
				bl_en_q  <= bl_en_n;
				to_cnt_q <= to_cnt_n;
				addr_q   <= addr_n;
				mv_q     <= mv_n;
				dth_q    <= dth_n;
				dhu_q    <= dhu_n;
				dte_q    <= dte_n;
				dun_q    <= dun_n;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_measure_keeps_mv: assert property (@(posedge clk) disable iff (!arst_n)
		upd && item.ctl.operation == OP_MEASURE |=> mv_q == $past(item.mv))
		else $error("measurement did not store its voltage");
	a_receive_advances: assert property (@(posedge clk) disable iff (!arst_n)
		upd && item.ctl.operation == OP_RECEIVE |=>
		addr_q == $past(addr_q) + ADDR_STEP && to_cnt_q == TIMEOUT_LOAD)
		else $error("receive complete did not advance address or load timeout");
	a_wake_rearms: assert property (@(posedge clk) disable iff (!arst_n)
		upd && item.ctl.operation == OP_WAKE |=> bl_en_q && bl_cnt_q == $past(reload_q))
		else $error("wake did not re-arm the backlight");
`endif

endmodule

// ----- sv/battery_gauge_backlight_timer.sv -----
// ----------------------------------------------------------------------------
// Battery gauge and backlight timer
// Event processor for tick, measurement, wake and receive-complete requests.
// ----------------------------------------------------------------------------
//
//  channel | signals                        | direction | notes
//  --------+--------------------------------+-----------+------------------------
//  evt     | evt_valid, evt_stall, evt_item | in        | one event per request
//  res     | res_valid, res_stall, res_item | out       | one result per event
//  cfg     | cfg_valid, cfg_ready, cfg_*    | in        | register writes
//
// The request is caught in the input register, then passes the scaling
// multiply, the divide by 4095 and the decimal split, and the state update
// loads the result register. One event is accepted per cycle while
// evt_stall is low.
// Reset is asynchronous and active low; it restores the register defaults.
// A stall on the result side fills empty pipeline stages first; evt_stall
// rises only when every stage holds a request.
//
module battery_gauge_backlight_timer (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               evt_valid,
	output logic                               evt_stall,
	input  bgbt_pkg::in_item_t                 evt_item,
	output logic                               res_valid,
	input  logic                               res_stall,
	output bgbt_pkg::res_item_t                res_item,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bgbt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [7:0]                         cfg_data
);
	import bgbt_pkg::*;

	// Intermediate stage payloads.
	typedef struct packed {
		ctl_t        ctl;
		logic [24:0] product;
	} prod_t;

	typedef struct packed {
		ctl_t        ctl;
		logic [12:0] mv;
	} volt_t;

	// Stage valid bits and handshake.
	logic v_s1, v_s2, v_s3, v_s4, res_valid_q;
	logic rdy1, rdy2, rdy3, rdy4, rdy_out, upd;

	in_item_t  item_s1;
	prod_t     prod_s2, prod_d;
	volt_t     volt_s3, volt_d;
	meas_t     meas_s4, meas_d;
	res_item_t res_q, res_next;
	cfg_wr_t   cfg;

	// Work signals of the arithmetic stages.
	logic [13:0] sum;
	logic [25:0] acc;
	logic [12:0] quo;
	logic [24:0] rem_div;
	logic [9:0]  rem1;

	// The result register frees when it is empty or being taken; each
	// earlier stage can move when it is empty or the next one can move.
	assign rdy_out   = !res_valid_q || !res_stall;
	assign rdy4      = !v_s4 || rdy_out;
	assign rdy3      = !v_s3 || rdy4;
	assign rdy2      = !v_s2 || rdy3;
	assign rdy1      = !v_s1 || rdy2;
	assign upd       = v_s4 && rdy_out;
	assign evt_stall = !rdy1;
	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	// Configuration writes are always taken; they land in the state block.
	assign cfg_ready = 1'b1;
	assign cfg.valid = cfg_valid;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	// Stage 2: average of the four samples times the millivolt scale.
	always_comb begin
		sum = 14'(item_s1.sample0) + 14'(item_s1.sample1)
		    + 14'(item_s1.sample2) + 14'(item_s1.sample3);
		prod_d.ctl.operation       = item_s1.operation;
		prod_d.ctl.charging_mode   = item_s1.charging_mode;
		prod_d.ctl.idle_mode       = item_s1.idle_mode;
		prod_d.ctl.charge_done_pin = item_s1.charge_done_pin;
		prod_d.product = 25'(sum >> 2) * 25'(MV_SCALE);
	end

	// Stage 3: divide by 4095. Since 1/4095 is just above 1/4096, the
	// estimate (p + p/4096)/4096 is low by at most one, and one compare
	// of the remainder corrects it.
	always_comb begin
		acc     = 26'(prod_s2.product) + 26'(prod_s2.product >> 12);
		quo     = 13'(acc >> 12);
		rem_div = prod_s2.product - (25'({quo, 12'b0}) - 25'(quo));
		volt_d.ctl = prod_s2.ctl;
		volt_d.mv  = (rem_div >= 25'(MV_DIV)) ? quo + 13'd1 : quo;
	end

	// Stage 4: icon class of the voltage, thousands and hundreds digits.
	always_comb begin
		meas_d.ctl    = volt_s3.ctl;
		meas_d.mv     = volt_s3.mv;
		meas_d.dig_th = lead_digit({1'b0, volt_s3.mv}, 14'd1000);
		rem1          = 10'(volt_s3.mv - 13'(meas_d.dig_th) * 13'd1000);
		meas_d.dig_hu = lead_digit(14'(rem1), 14'd100);
		meas_d.rem    = 7'(rem1 - 10'(meas_d.dig_hu) * 10'd100);

		meas_d.cls_hit  = 1'b1;
		meas_d.cls_low  = 1'b0;
		meas_d.cls_code = ICON_EMPTY;
		priority if (volt_s3.mv >= 13'd4200) begin
			// Above the top band the icon stays as it is.
			meas_d.cls_hit = 1'b0;
		end else if (volt_s3.mv >= 13'd4000) begin
			meas_d.cls_code = ICON_FULL;
		end else if (volt_s3.mv >= 13'd3900) begin
			meas_d.cls_code = 4'hC;
		end else if (volt_s3.mv >= 13'd3800) begin
			meas_d.cls_code = 4'hD;
		end else if (volt_s3.mv >= 13'd3700) begin
			meas_d.cls_code = 4'hE;
		end else if (volt_s3.mv >= 13'd3500) begin
			meas_d.cls_code = ICON_EMPTY;
		end else begin
			// Low battery: flag it and leave the icon alone.
			meas_d.cls_hit = 1'b0;
			meas_d.cls_low = 1'b1;
		end
	end

	// Stage 5: the state block applies the event and forms the result.
	bgbt_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.upd    (upd),
		.item   (meas_s4),
		.res    (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= evt_valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			if (rdy4) begin
				v_s4 <= v_s3;
			end
			if (rdy_out) begin
				res_valid_q <= v_s4;
			end
		end
	end

	// Payload registers load only when a request moves into them.
	always_ff @(posedge clk) begin
		if (rdy1 && evt_valid) begin
			item_s1 <= evt_item;
		end
		if (rdy2 && v_s1) begin
			prod_s2 <= prod_d;
		end
		if (rdy3 && v_s2) begin
			volt_s3 <= volt_d;
		end
		if (rdy4 && v_s3) begin
			meas_s4 <= meas_d;
		end
		if (upd) begin
			res_q <= res_next;
		end
	end

`ifndef NO_ASSERTIONS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		evt_stall |-> v_s1 && v_s2 && v_s3 && v_s4 && res_valid && res_stall)
		else $error("input stalled while a pipeline stage was free");
	a_digits_match_mv: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> 14'(res_item.millivolts) ==
		14'(res_item.digit_thousands[3:0]) * 14'd1000
		+ 14'(res_item.digit_hundreds[3:0]) * 14'd100
		+ 14'(res_item.digit_tens[3:0]) * 14'd10
		+ 14'(res_item.digit_units[3:0]))
		else $error("decimal digits disagree with millivolts");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && !v_s4 |=> !res_valid)
		else $error("result register kept a taken result");
`endif

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery gauge and backlight timer testbench
// Sends tick, measurement, wake and receive-complete requests through the
// event channel under random idling, predicts each result in a behavioral
// model of the gauge, and checks every returned result field by field.
// ----------------------------------------------------------------------------
module tb_top;
	import bgbt_pkg::*;

	// Icon codes between full and empty; the package names only the ends.
	localparam logic [3:0] ICON_BARS3 = 4'hC;
	localparam logic [3:0] ICON_BARS2 = 4'hD;
	localparam logic [3:0] ICON_BARS1 = 4'hE;

	// Register indexes past the last real one are accepted and ignored.
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_BL_OFF_LEVEL + 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_TOP          = {CFG_IDX_W{1'b1}};

	// The pipeline is five stages deep; this is a comfortable margin on top.
	localparam int SETTLE_CYCLES = 16;
	localparam int TIMEOUT_NS    = 1_000_000;

	typedef struct packed {
		in_item_t  ev;
		logic      typed;
		res_item_t want;
	} stim_row_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      evt_valid = 1'b0;
	logic      evt_stall;
	in_item_t  evt_item  = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	res_item_t res_item;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	battery_gauge_backlight_timer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt_item  (evt_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Gauge state as the block should hold it, plus the two registers.
	logic [3:0]  icon_q;
	logic [7:0]  bl_count_q;
	logic        bl_enable_q;
	logic [7:0]  rx_timeout_q;
	logic [15:0] rx_addr_q;
	logic [12:0] mv_q;
	logic [7:0]  cfg_reload_q;
	logic [7:0]  cfg_off_q;

	// Results owed by the block, oldest first.
	res_item_t gauge_reports_due[$];

	// Idling odds: one burst per that many requests (gaps) or cycles (stalls) on average, zero for none.
	int unsigned gap_odds   = 0;
	int unsigned stall_odds = 0;

	int n_sent      = 0;
	int n_checked   = 0;
	int mismatches  = 0;
	int n_ticks     = 0;
	int n_measures  = 0;
	int n_releases  = 0;
	int n_timeouts  = 0;
	int n_low       = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("battery_gauge_backlight_timer test failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Gauge predictor
	// ------------------------------------------------------------------

	function automatic void gauge_reset();
		cfg_reload_q = BL_RELOAD_RESET;
		cfg_off_q    = BL_OFF_RESET;
		icon_q       = ICON_EMPTY;
		bl_count_q   = BL_RELOAD_RESET;
		bl_enable_q  = 1'b1;
		rx_timeout_q = '0;
		rx_addr_q    = '0;
		mv_q         = '0;
	endfunction

	// Applies one request to the predicted state and returns the result the
	// block must produce for it.
	function automatic res_item_t gauge_step(input in_item_t ev);
		res_item_t   r;
		int unsigned avg;
		int unsigned mv;
		r = '0;
		case (ev.operation)
			OP_TICK: begin
				// Charging animation: the icon walks down from empty toward full and
				// wraps to empty after full, except that a finished charge parks it
				// at full.
				if (ev.charging_mode && !(icon_q == ICON_FULL && ev.charge_done_pin)) begin
					icon_q = icon_q - 4'd1;
					if (icon_q == ICON_WRAP)
						icon_q = ICON_EMPTY;
				end
				if (bl_count_q != 8'd0)
					bl_count_q = bl_count_q - 8'd1;
				else if (ev.idle_mode)
					r.power_release = 1'b1;
				if (bl_count_q < cfg_off_q)
					bl_enable_q = 1'b0;
				// A count already at zero wraps around without raising the flag.
				rx_timeout_q = rx_timeout_q - 8'd1;
				if (rx_timeout_q == 8'd0)
					r.timeout_flag = 1'b1;
			end
			OP_MEASURE: begin
				avg = (int'(ev.sample0) + int'(ev.sample1) + int'(ev.sample2)
					+ int'(ev.sample3)) / 4;
				mv  = (int'(MV_SCALE) * avg) / int'(MV_DIV);
				// At 4200 mV and above the icon is left alone.
				if (mv >= 4200)
					;
				else if (mv >= 4000)
					icon_q = ICON_FULL;
				else if (mv >= 3900)
					icon_q = ICON_BARS3;
				else if (mv >= 3800)
					icon_q = ICON_BARS2;
				else if (mv >= 3700)
					icon_q = ICON_BARS1;
				else if (mv >= 3500)
					icon_q = ICON_EMPTY;
				else
					r.battery_low = 1'b1;
				mv_q        = 13'(mv);
				bl_count_q  = cfg_reload_q;
				bl_enable_q = 1'b1;
			end
			OP_WAKE: begin
				bl_count_q  = cfg_reload_q;
				bl_enable_q = 1'b1;
			end
			default: begin
				rx_addr_q    = rx_addr_q + ADDR_STEP;
				rx_timeout_q = TIMEOUT_LOAD;
			end
		endcase
		r.battery_code    = icon_q;
		r.backlight_on    = bl_enable_q;
		r.millivolts      = mv_q;
		r.digit_thousands = ASCII_ZERO | 6'(mv_q / 1000);
		r.digit_hundreds  = ASCII_ZERO | 6'((mv_q % 1000) / 100);
		r.digit_tens      = ASCII_ZERO | 6'((mv_q % 100) / 10);
		r.digit_units     = ASCII_ZERO | 6'(mv_q % 10);
		r.block_address   = rx_addr_q;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic in_item_t ev_of(input logic [1:0] op, input logic chg,
		input logic idle, input logic pin, input logic [11:0] s0,
		input logic [11:0] s1, input logic [11:0] s2, input logic [11:0] s3);
		in_item_t ev;
		ev.operation       = op;
		ev.charging_mode   = chg;
		ev.idle_mode       = idle;
		ev.charge_done_pin = pin;
		ev.sample0         = s0;
		ev.sample1         = s1;
		ev.sample2         = s2;
		ev.sample3         = s3;
		return ev;
	endfunction

	function automatic in_item_t meas_avg(input logic [11:0] s);
		return ev_of(OP_MEASURE, 1'b0, 1'b0, 1'b0, s, s, s, s);
	endfunction

	// Expected result with the digits given as plain decimal values.
	function automatic res_item_t res_of(input logic [3:0] code, input logic low,
		input logic on, input logic rel, input logic tf, input logic [12:0] mv,
		input int dth, input int dhu, input int dte, input int dun,
		input logic [15:0] addr);
		res_item_t r;
		r.battery_code    = code;
		r.battery_low     = low;
		r.backlight_on    = on;
		r.power_release   = rel;
		r.timeout_flag    = tf;
		r.millivolts      = mv;
		r.digit_thousands = ASCII_ZERO | 6'(dth);
		r.digit_hundreds  = ASCII_ZERO | 6'(dhu);
		r.digit_tens      = ASCII_ZERO | 6'(dte);
		r.digit_units     = ASCII_ZERO | 6'(dun);
		r.block_address   = addr;
		return r;
	endfunction

	// Mode 0 gives any value, mode 1 the rails, anything else a value near
	// the centre so that the average lands in the classification bands.
	function automatic logic [11:0] sample_near(input int unsigned mode,
		input int unsigned centre);
		if (mode == 0)
			return 12'($urandom);
		else if (mode == 1)
			return $urandom_range(0, 1) ? 12'hFFF : 12'h000;
		else
			return 12'(centre + $urandom_range(0, 16) - 8);
	endfunction

	function automatic in_item_t rand_event(input logic [1:0] op);
		int unsigned mode;
		int unsigned centre;
		mode   = $urandom_range(0, 9);
		centre = $urandom_range(2100, 2700);
		return ev_of(op, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), sample_near(mode, centre),
			sample_near(mode, centre), sample_near(mode, centre),
			sample_near(mode, centre));
	endfunction

	function automatic logic [1:0] rand_op();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return OP_TICK;
		else if (r < 7)
			return OP_MEASURE;
		else if (r < 8)
			return OP_WAKE;
		else
			return OP_RECEIVE;
	endfunction

	// Presents one request, holds it until it is taken, and books the
	// result it is owed. Called at a rising edge; returns at the edge of
	// acceptance with evt_valid still high.
	task automatic send_event(input in_item_t ev, input logic typed = 1'b0,
		input res_item_t want = '0);
		res_item_t predicted;
		if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			evt_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		evt_valid <= 1'b1;
		evt_item  <= ev;
		@(posedge clk);
		while (evt_stall)
			@(posedge clk);
		predicted = gauge_step(ev);
		gauge_reports_due.push_back(typed ? want : predicted);
		n_sent++;
		if (ev.operation == OP_TICK)
			n_ticks++;
		if (ev.operation == OP_MEASURE)
			n_measures++;
		if (predicted.power_release)
			n_releases++;
		if (predicted.timeout_flag)
			n_timeouts++;
		if (predicted.battery_low)
			n_low++;
	endtask

	task automatic drain_results();
		evt_valid <= 1'b0;
		while (gauge_reports_due.size() != 0)
			@(posedge clk);
	endtask

	// Register write; the block is idle whenever this is called.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_BL_RELOAD)
			cfg_reload_q = val;
		else if (idx == REG_BL_OFF_LEVEL)
			cfg_off_q = val;
		@(posedge clk);
	endtask

	// Random traffic built mostly from short sequences that drive the
	// counters to their interesting points: a receive followed by the ticks
	// that run its timeout out, a backlight reload followed by enough ticks
	// to expire it when the reload is at most 30, and charging runs that animate the icon.
	task automatic run_random(input int n_items);
		int       start;
		int       cnt;
		in_item_t ev;
		start = n_sent;
		while (n_sent - start < n_items) begin
			case ($urandom_range(0, 9))
				0, 1, 2: send_event(rand_event(rand_op()));
				3, 4: begin
					send_event(rand_event(OP_RECEIVE));
					repeat ($urandom_range(1, 4)) send_event(rand_event(OP_TICK));
				end
				5, 6: begin
					send_event(rand_event($urandom_range(0, 1) ? OP_WAKE : OP_MEASURE));
					cnt = (cfg_reload_q > 30 ? 30 : int'(cfg_reload_q))
						+ $urandom_range(0, 3);
					repeat (cnt) send_event(rand_event(OP_TICK));
				end
				7, 8: begin
					repeat ($urandom_range(3, 12)) begin
						ev = rand_event(OP_TICK);
						ev.charging_mode = 1'b1;
						send_event(ev);
					end
				end
				default: repeat ($urandom_range(1, 4)) send_event(rand_event(OP_MEASURE));
			endcase
		end
	endtask

	// One setting of the registers, with an ignored write to an unused
	// index each time, followed by random traffic under the given idling.
	task automatic run_phase(input logic [7:0] reload, input logic [7:0] off_level,
		input int n_items, input int unsigned gaps, input int unsigned stalls);
		drain_results();
		write_reg(REG_BL_RELOAD, reload);
		write_reg(REG_BL_OFF_LEVEL, off_level);
		write_reg(CFG_IDX_W'($urandom_range(REG_FIRST_UNUSED, REG_TOP)), 8'($urandom));
		gap_odds   = gaps;
		stall_odds = stalls;
		run_random(n_items);
	endtask

	// ------------------------------------------------------------------
	// Result side: random stall bursts and the checker
	// ------------------------------------------------------------------

	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	task automatic cmp_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		res_item_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (gauge_reports_due.size() == 0) begin
				$error("result arrived with none outstanding");
				mismatches++;
			end else begin
				want = gauge_reports_due.pop_front();
				cmp_field("battery_code", want.battery_code, res_item.battery_code);
				cmp_field("battery_low", want.battery_low, res_item.battery_low);
				cmp_field("backlight_on", want.backlight_on, res_item.backlight_on);
				cmp_field("power_release", want.power_release, res_item.power_release);
				cmp_field("timeout_flag", want.timeout_flag, res_item.timeout_flag);
				cmp_field("millivolts", want.millivolts, res_item.millivolts);
				cmp_field("digit_thousands", want.digit_thousands,
					res_item.digit_thousands);
				cmp_field("digit_hundreds", want.digit_hundreds, res_item.digit_hundreds);
				cmp_field("digit_tens", want.digit_tens, res_item.digit_tens);
				cmp_field("digit_units", want.digit_units, res_item.digit_units);
				cmp_field("block_address", want.block_address, res_item.block_address);
				n_checked++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin
		stim_row_t dir_rows[$];
		gauge_reset();

		// Directed requests. Rows with a typed result can be worked out by
		// hand from the reset state; the rest go through the predictor.
		// Tick straight after reset: the timeout counter wraps from zero
		// without a flag.
		dir_rows.push_back('{ev_of(OP_TICK, 1'b0, 1'b0, 1'b0, '0, '0, '0, '0), 1'b1,
			res_of(ICON_EMPTY, 1'b0, 1'b1, 1'b0, 1'b0, 13'd0, 0, 0, 0, 0, 16'h0000)});
		// Receive complete moves the address one block on and arms the timeout.
		dir_rows.push_back('{ev_of(OP_RECEIVE, 1'b0, 1'b0, 1'b0, '0, '0, '0, '0), 1'b1,
			res_of(ICON_EMPTY, 1'b0, 1'b1, 1'b0, 1'b0, 13'd0, 0, 0, 0, 0, 16'h0100)});
		// Two ticks run the timeout out, a third wraps it again.
		dir_rows.push_back('{ev_of(OP_TICK, 1'b0, 1'b1, 1'b0, '0, '0, '0, '0), 1'b0, '0});
		dir_rows.push_back('{ev_of(OP_TICK, 1'b0, 1'b1, 1'b0, '0, '0, '0, '0), 1'b0, '0});
		dir_rows.push_back('{ev_of(OP_TICK, 1'b0, 1'b0, 1'b0, '0, '0, '0, '0), 1'b0, '0});
		// Full-scale samples give the top voltage, which leaves the icon alone.
		dir_rows.push_back('{meas_avg(12'hFFF), 1'b1,
			res_of(ICON_EMPTY, 1'b0, 1'b1, 1'b0, 1'b0, 13'd6590, 6, 5, 9, 0, 16'h0100)});
		// Zero samples: below the low limit, icon unchanged, low flag set.
		dir_rows.push_back('{meas_avg(12'h000), 1'b1,
			res_of(ICON_EMPTY, 1'b1, 1'b1, 1'b0, 1'b0, 13'd0, 0, 0, 0, 0, 16'h0100)});
		// Either side of the 4200 mV edge; the lower one sets the icon full.
		dir_rows.push_back('{meas_avg(12'd2610), 1'b0, '0});
		dir_rows.push_back('{meas_avg(12'd2609), 1'b0, '0});
		// Charging at full: the done pin holds it, otherwise it wraps to
		// empty and keeps walking down; the pin matters only at full.
		dir_rows.push_back('{ev_of(OP_TICK, 1'b1, 1'b0, 1'b1, '0, '0, '0, '0), 1'b0, '0});
		dir_rows.push_back('{ev_of(OP_TICK, 1'b1, 1'b0, 1'b0, '0, '0, '0, '0), 1'b0, '0});
		dir_rows.push_back('{ev_of(OP_TICK, 1'b1, 1'b0, 1'b0, '0, '0, '0, '0), 1'b0, '0});
		dir_rows.push_back('{ev_of(OP_TICK, 1'b1, 1'b1, 1'b1, '0, '0, '0, '0), 1'b0, '0});
		// One measurement inside each classification band.
		dir_rows.push_back('{meas_avg(12'd2455), 1'b0, '0});
		dir_rows.push_back('{meas_avg(12'd2392), 1'b0, '0});
		dir_rows.push_back('{meas_avg(12'd2330), 1'b0, '0});
		dir_rows.push_back('{meas_avg(12'd2237), 1'b0, '0});
		// Exactly 3500 mV, then just under it.
		dir_rows.push_back('{meas_avg(12'd2175), 1'b0, '0});
		dir_rows.push_back('{meas_avg(12'd2174), 1'b0, '0});
		// Unequal samples with the same average; control bits do not matter.
		dir_rows.push_back('{ev_of(OP_MEASURE, 1'b1, 1'b1, 1'b1, 12'd2546, 12'd2550,
			12'd2547, 12'd2549), 1'b0, '0});
		dir_rows.push_back('{ev_of(OP_WAKE, 1'b1, 1'b1, 1'b1, 12'hFFF, 12'hFFF,
			12'hFFF, 12'hFFF), 1'b0, '0});
		dir_rows.push_back('{ev_of(OP_TICK, 1'b1, 1'b1, 1'b1, '0, '0, '0, '0), 1'b0, '0});
		dir_rows.push_back('{ev_of(OP_RECEIVE, 1'b1, 1'b1, 1'b1, '0, '0, '0, '0), 1'b0, '0});
		dir_rows.push_back('{ev_of(OP_TICK, 1'b0, 1'b1, 1'b1, '0, '0, '0, '0), 1'b0, '0});

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		gap_odds   = 4;
		stall_odds = 4;
		foreach (dir_rows[i])
			send_event(dir_rows[i].ev, dir_rows[i].typed, dir_rows[i].want);

		// Register extremes around a run with no idling, then a random
		// setting under heavy idling, and back to the defaults for a quiet
		// tail with no idling on either side.
		run_phase(8'd0,   8'd0,   250, 5, 5);
		run_phase(8'd255, 8'd255, 200, 8, 3);
		run_phase(8'd5,   8'd3,   250, 0, 0);
		run_phase(8'd255, 8'd0,   175, 3, 8);
		run_phase(8'($urandom_range(0, 40)), 8'($urandom_range(0, 40)), 325, 2, 2);
		run_phase(BL_RELOAD_RESET, BL_OFF_RESET, 225, 0, 0);

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d requests (%0d ticks, %0d measurements), checked %0d results.",
			n_sent, n_ticks, n_measures, n_checked);
		$display("Seen: %0d power releases, %0d receive timeouts, %0d low-battery readings.",
			n_releases, n_timeouts, n_low);
		if (mismatches == 0 && gauge_reports_due.size() == 0)
			$display("battery_gauge_backlight_timer test passed");
		else
			$display("battery_gauge_backlight_timer test failed");
		$finish;
	end

endmodule
